### src/mfrs_pkg.sv
// Shared types, codes and helpers of the matrix flip/rotate sequence block.
package mfrs_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ACTION = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Action kinds
  localparam logic ACT_ROTATE = 1'b0;
  localparam logic ACT_FLIP   = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam int DIM_W  = 4;
  localparam int DATA_W = 16;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] element;
    logic                     action_kind;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [DIM_W-1:0]         out_rows;
    logic [DIM_W-1:0]         out_cols;
    logic                     last;
  } result_t;

  // One finish job handed from the front to the back
  typedef struct packed {
    logic [1:0]       rot;
    logic             flip;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } job_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### src/mfrs_front.sv
// Front end: accepts items, loads the store, composes actions, queues finish jobs.
module mfrs_front #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  parameter int AW       = 6,
  parameter int LW       = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  mfrs_pkg::item_t              item,
  input  logic [mfrs_pkg::DIM_W-1:0]   row_count,
  input  logic [mfrs_pkg::DIM_W-1:0]   col_count,
  input  logic                         back_active,
  output logic                         store_we,
  output logic [AW-1:0]                store_waddr,
  output logic [mfrs_pkg::DATA_W-1:0]  store_wdata,
  output logic                         job_valid,
  output mfrs_pkg::job_t               job,
  input  logic                         job_take
);

  logic [LW-1:0]                load_index;
  logic [1:0]                   rot;
  logic                         flip;
  logic [mfrs_pkg::DIM_W-1:0]   rows;
  logic [mfrs_pkg::DIM_W-1:0]   cols;
  logic [7:0]                   total;
  logic                         is_load;
  logic                         accept;
  logic                         job_push;
  logic                         busy;

  // two-entry job queue
  mfrs_pkg::job_t               jq [2];
  logic                         jq_wp;
  logic                         jq_rp;
  logic [1:0]                   jq_cnt;
  logic                         jq_full;

  assign rows  = mfrs_pkg::clamp_dim(row_count, mfrs_pkg::DIM_W'(MAX_ROWS));
  assign cols  = mfrs_pkg::clamp_dim(col_count, mfrs_pkg::DIM_W'(MAX_COLS));
  assign total = 8'(rows) * 8'(cols);

  // Loads wait while an earlier matrix still streams out of the store
  assign jq_full  = (jq_cnt == 2'd2);
  assign busy     = (jq_cnt != 2'd0) || back_active;
  assign is_load  = (item.func == mfrs_pkg::FUNC_LOAD);
  assign full     = jq_full || (is_load && busy);
  assign accept   = push && !full;
  assign job_push = accept && (item.func == mfrs_pkg::FUNC_FINISH);

  // Store write port
  assign store_we    = accept && is_load && (8'(load_index) < total);
  assign store_waddr = load_index[AW-1:0];
  assign store_wdata = item.element;

  // Transform and load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      rot        <= 2'd0;
      flip       <= 1'b0;
    end else if (accept) begin
      case (item.func)
        mfrs_pkg::FUNC_LOAD: begin
          if (store_we) begin
            load_index <= load_index + LW'(1);
          end
        end
        mfrs_pkg::FUNC_ACTION: begin
          // new action applies first; a rotation behind a flip turns the other way
          if (item.action_kind == mfrs_pkg::ACT_FLIP) begin
            flip <= !flip;
          end else begin
            rot <= rot + (flip ? 2'd3 : 2'd1);
          end
        end
        mfrs_pkg::FUNC_FINISH: begin
          load_index <= '0;
          rot        <= 2'd0;
          flip       <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Job queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      jq_wp  <= 1'b0;
      jq_rp  <= 1'b0;
      jq_cnt <= 2'd0;
    end else begin
      if (job_push) begin
        jq_wp <= !jq_wp;
      end
      if (job_take) begin
        jq_rp <= !jq_rp;
      end
      jq_cnt <= jq_cnt + 2'(job_push) - 2'(job_take);
    end
  end

  // Job queue payload
  always_ff @(posedge clk) begin
    if (job_push) begin
      jq[jq_wp] <= '{rot: rot, flip: flip, rows: rows, cols: cols};
    end
  end

  assign job_valid = (jq_cnt != 2'd0);
  assign job       = jq[jq_rp];

endmodule

### src/mfrs_back.sv
// Back end: matrix store, transformed-order address walk and result queue.
module mfrs_back #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  parameter int AW       = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         store_we,
  input  logic [AW-1:0]                store_waddr,
  input  logic [mfrs_pkg::DATA_W-1:0]  store_wdata,
  input  logic                         job_valid,
  input  mfrs_pkg::job_t               job,
  output logic                         job_take,
  output logic                         active,
  output logic                         empty,
  input  logic                         pop,
  output mfrs_pkg::result_t            result
);

  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int FIFO_DEPTH = 4;

  logic [mfrs_pkg::DATA_W-1:0]  mem [DEPTH];

  // current job
  logic [1:0]                   rot;
  logic                         flip;
  logic [mfrs_pkg::DIM_W-1:0]   rows;
  logic [mfrs_pkg::DIM_W-1:0]   cols;
  logic [mfrs_pkg::DIM_W-1:0]   oh;
  logic [mfrs_pkg::DIM_W-1:0]   ow;
  logic [mfrs_pkg::DIM_W-1:0]   i;
  logic [mfrs_pkg::DIM_W-1:0]   j;

  logic                         start;
  logic                         issue;
  logic                         is_last;
  logic                         row_end;
  logic [mfrs_pkg::DIM_W-1:0]   ci;
  logic [mfrs_pkg::DIM_W-1:0]   cj;
  logic [mfrs_pkg::DIM_W-1:0]   ci_f;
  logic [7:0]                   addr8;
  logic [AW-1:0]                raddr;

  // read stage
  logic                         rd_valid;
  logic [mfrs_pkg::DATA_W-1:0]  rd_data;
  logic [mfrs_pkg::DIM_W-1:0]   rd_rows;
  logic [mfrs_pkg::DIM_W-1:0]   rd_cols;
  logic                         rd_last;

  // result queue
  mfrs_pkg::result_t            fifo [FIFO_DEPTH];
  logic [1:0]                   wp;
  logic [1:0]                   rp;
  logic [2:0]                   cnt;
  logic                         pop_ok;

  assign start    = !active && job_valid;
  assign job_take = start;

  // room for the beat in flight plus this one
  assign issue   = active && ((cnt + 3'(rd_valid)) < 3'(FIFO_DEPTH));
  assign row_end = (j == ow - 4'd1);
  assign is_last = row_end && (i == oh - 4'd1);

  // Source coordinates for output position (i, j)
  always_comb begin
    unique case (rot)
      2'd0: begin
        ci = i;
        cj = j;
      end
      2'd1: begin
        ci = rows - 4'd1 - j;
        cj = i;
      end
      2'd2: begin
        ci = rows - 4'd1 - i;
        cj = cols - 4'd1 - j;
      end
      2'd3: begin
        ci = j;
        cj = cols - 4'd1 - i;
      end
    endcase
    ci_f  = flip ? (rows - 4'd1 - ci) : ci;
    addr8 = 8'(ci_f) * 8'(cols) + 8'(cj);
    raddr = addr8[AW-1:0];
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (start) begin
        active <= 1'b1;
      end else if (issue && is_last) begin
        active <= 1'b0;
      end
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    if (start) begin
      rot  <= job.rot;
      flip <= job.flip;
      rows <= job.rows;
      cols <= job.cols;
      oh   <= job.rot[0] ? job.cols : job.rows;
      ow   <= job.rot[0] ? job.rows : job.cols;
      i    <= '0;
      j    <= '0;
    end else if (issue) begin
      if (row_end) begin
        j <= '0;
        i <= i + 4'd1;
      end else begin
        j <= j + 4'd1;
      end
    end
    if (issue) begin
      rd_rows <= oh;
      rd_cols <= ow;
      rd_last <= is_last;
    end
  end

  // Matrix store
  always_ff @(posedge clk) begin
    if (store_we) begin
      mem[store_waddr] <= store_wdata;
    end
    if (issue) begin
      rd_data <= mem[raddr];
    end
  end

  // Result queue
  assign pop_ok = pop && !empty;
  assign empty  = (cnt == 3'd0);
  assign result = fifo[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (rd_valid) begin
        wp <= wp + 2'd1;
      end
      if (pop_ok) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + 3'(rd_valid) - 3'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      fifo[wp] <= '{value: rd_data, out_rows: rd_rows, out_cols: rd_cols, last: rd_last};
    end
  end

endmodule

### src/matrix_flip_rotate_sequence.sv
// Top level of the matrix flip/rotate sequence block: config registers and the two halves.
//
//  channel   kind       handshake                       beat
//  item      queue in   push / full                     func, element, action_kind
//  result    queue out  pop / empty                     value, out_rows, out_cols, last
//  config    APB        psel, penable, pwrite, pready   row_count @0x0, col_count @0x4
//
// Load and action items update state when accepted. A finish queues a job, then the
// matrix streams out at one element per cycle while the result queue has room
// (rows*cols beats), paced by the store's single read port; a queued job waits for idle.
// Loads stall (full high) while a finished matrix is still being read out.
// Synchronous active-high reset clears counters, transform and queues; store
// contents are not cleared.
module matrix_flip_rotate_sequence #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  mfrs_pkg::item_t      item,
  output logic                 empty,
  input  logic                 pop,
  output mfrs_pkg::result_t    result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);

  logic [mfrs_pkg::DIM_W-1:0]   row_count;
  logic [mfrs_pkg::DIM_W-1:0]   col_count;
  logic                         cfg_wr;

  logic                         store_we;
  logic [AW-1:0]                store_waddr;
  logic [mfrs_pkg::DATA_W-1:0]  store_wdata;
  logic                         job_valid;
  mfrs_pkg::job_t               job;
  logic                         job_take;
  logic                         back_active;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= mfrs_pkg::DIM_W'(1);
      col_count <= mfrs_pkg::DIM_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == mfrs_pkg::REG_ROW_COUNT) begin
        row_count <= pwdata[mfrs_pkg::DIM_W-1:0];
      end
      if (paddr[2] == mfrs_pkg::REG_COL_COUNT) begin
        col_count <= pwdata[mfrs_pkg::DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == mfrs_pkg::REG_COL_COUNT) ? 32'(col_count) : 32'(row_count);

  mfrs_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW),
    .LW       (LW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .row_count   (row_count),
    .col_count   (col_count),
    .back_active (back_active),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .job_valid   (job_valid),
    .job         (job),
    .job_take    (job_take)
  );

  mfrs_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .job_valid   (job_valid),
    .job         (job),
    .job_take    (job_take),
    .active      (back_active),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

  // The store is never written while a matrix is being read out of it
  a_no_load_during_stream: assert property (@(posedge clk) disable iff (rst)
    store_we |-> !back_active && !job_valid)
    else $error("store written during readout");

  // A queued job is picked up by an idle back end on the next edge
  a_job_start: assert property (@(posedge clk) disable iff (rst)
    job_valid && !back_active |=> back_active)
    else $error("queued job not started");

  // Loads are held off while a job is pending
  a_load_held: assert property (@(posedge clk) disable iff (rst)
    job_valid && item.func == mfrs_pkg::FUNC_LOAD |-> full)
    else $error("load accepted with a job pending");

endmodule

### dv/matrix_flip_rotate_sequence_checker.sv
// Checker for the matrix flip/rotate sequence block: predicts emitted matrices and checks beats.
`timescale 1ns / 1ps

module matrix_flip_rotate_sequence_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  mfrs_pkg::item_t     item,
  input  logic                empty,
  input  logic                pop,
  input  mfrs_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  elements_due,
  output int                  beats_checked,
  output int                  matrices_done
);

  localparam int STORE_SLOTS = 64;
  localparam int DIM_MAX     = 8;
  localparam int PRINT_CAP   = 50;

  // Shadow of the block state
  logic signed [mfrs_pkg::DATA_W-1:0] elem_store [STORE_SLOTS];
  logic [6:0]                         fill_ptr;
  logic [1:0]                         quarter_turns;
  logic                               mirrored;
  logic [mfrs_pkg::DIM_W-1:0]         rows_reg;
  logic [mfrs_pkg::DIM_W-1:0]         cols_reg;
  mfrs_pkg::result_t                  due_beats [$];

  // Register value as the block uses it: zero reads as one, top saturates
  function automatic int eff_dim(logic [mfrs_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  task automatic flag(string what, int want, int got);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    end
    mismatches++;
  endtask

  // Walk the output matrix row-major, map each position back to the loaded one
  task automatic queue_transformed_matrix();
    int rows, cols, oh, ow, n, r, c, k, src_r, src_c, h, w, tmp;
    mfrs_pkg::result_t beat;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    oh = quarter_turns[0] ? cols : rows;
    ow = quarter_turns[0] ? rows : cols;
    n = 0;
    for (r = 0; r < oh; r++) begin
      for (c = 0; c < ow; c++) begin
        src_r = r;
        src_c = c;
        h = oh;
        w = ow;
        // undo each clockwise quarter turn
        for (k = 0; k < int'(quarter_turns); k++) begin
          tmp   = src_r;
          src_r = w - 1 - src_c;
          src_c = tmp;
          tmp   = h;
          h     = w;
          w     = tmp;
        end
        if (mirrored) src_r = rows - 1 - src_r;
        beat.value    = elem_store[src_r * cols + src_c];
        beat.out_rows = mfrs_pkg::DIM_W'(oh);
        beat.out_cols = mfrs_pkg::DIM_W'(ow);
        beat.last     = (n + 1 == rows * cols);
        due_beats.push_back(beat);
        n++;
      end
    end
    quarter_turns = '0;
    mirrored      = 1'b0;
    fill_ptr      = '0;
    matrices_done++;
  endtask

  always @(posedge clk) begin : watch
    mfrs_pkg::result_t want;
    if (rst) begin
      fill_ptr      = '0;
      quarter_turns = '0;
      mirrored      = 1'b0;
      rows_reg      = mfrs_pkg::DIM_W'(1);
      cols_reg      = mfrs_pkg::DIM_W'(1);
      due_beats.delete();
    end else begin
      // result side: oldest prediction against the beat taken
      if (pop && !empty) begin
        if (due_beats.size() == 0) begin
          flag("result beat with nothing due, value", 0, int'(result.value));
        end else begin
          want = due_beats.pop_front();
          if (result.value !== want.value)
            flag("value", int'(want.value), int'(result.value));
          if (result.out_rows !== want.out_rows)
            flag("out_rows", int'(want.out_rows), int'(result.out_rows));
          if (result.out_cols !== want.out_cols)
            flag("out_cols", int'(want.out_cols), int'(result.out_cols));
          if (result.last !== want.last)
            flag("last", int'(want.last), int'(result.last));
          beats_checked++;
        end
      end

      // config port: track writes, check read data
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == mfrs_pkg::REG_COL_COUNT) cols_reg = pwdata[mfrs_pkg::DIM_W-1:0];
          else rows_reg = pwdata[mfrs_pkg::DIM_W-1:0];
        end else if (paddr[2] == mfrs_pkg::REG_COL_COUNT) begin
          if (prdata[mfrs_pkg::DIM_W-1:0] !== cols_reg)
            flag("col_count read", int'(cols_reg), int'(prdata[mfrs_pkg::DIM_W-1:0]));
        end else begin
          if (prdata[mfrs_pkg::DIM_W-1:0] !== rows_reg)
            flag("row_count read", int'(rows_reg), int'(prdata[mfrs_pkg::DIM_W-1:0]));
        end
      end

      // item side
      if (push && !full) begin
        case (item.func)
          mfrs_pkg::FUNC_LOAD: begin
            if (fill_ptr < eff_dim(rows_reg) * eff_dim(cols_reg)) begin
              elem_store[fill_ptr] = item.element;
              fill_ptr++;
            end
          end
          mfrs_pkg::FUNC_ACTION: begin
            // a turn queued behind a flip runs the other way
            if (item.action_kind == mfrs_pkg::ACT_FLIP) mirrored = !mirrored;
            else quarter_turns = quarter_turns + (mirrored ? 2'd3 : 2'd1);
          end
          mfrs_pkg::FUNC_FINISH: queue_transformed_matrix();
          default: ;
        endcase
      end
    end
    elements_due = due_beats.size();
  end

endmodule

### dv/matrix_flip_rotate_sequence_test.sv
// Testbench top for the matrix flip/rotate sequence block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module matrix_flip_rotate_sequence_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 8;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 40;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              push    = 1'b0;
  logic              full;
  mfrs_pkg::item_t   item    = '0;
  logic              empty;
  logic              pop     = 1'b0;
  mfrs_pkg::result_t result;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches, elements_due, beats_checked, matrices_done;

  // flow control knobs
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left  = 0;
  int cycles     = 0;

  // stimulus-side view of which store slots hold data
  bit loaded [64];
  int fill_idx   = 0;
  int act_rows   = 1;
  int act_cols   = 1;
  int items_sent = 0;

  // register settings per phase; 0 and 15 exercise clamping
  int cfg_rows [PHASES] = '{1, 8, 0, 15, 3, 2, 8, 1, 5, 15, 4, 0};
  int cfg_cols [PHASES] = '{1, 8, 5, 3, 15, 7, 1, 8, 6, 15, 4, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_flip_rotate_sequence dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  matrix_flip_rotate_sequence_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .elements_due  (elements_due),
    .beats_checked (beats_checked),
    .matrices_done (matrices_done)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, elements_due);
      $display("matrix_flip_rotate_sequence: mismatch");
      $finish;
    end
  end

  function automatic mfrs_pkg::item_t make_item(logic [1:0] f);
    mfrs_pkg::item_t it;
    it.func        = f;
    it.element     = 16'($urandom);
    it.action_kind = 1'($urandom);
    return it;
  endfunction

  function automatic bit store_ready();
    for (int a = 0; a < act_rows * act_cols; a++) begin
      if (!loaded[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One beat on the item side, with random idle cycles ahead of it
  task automatic send(mfrs_pkg::item_t it);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (elements_due != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [mfrs_pkg::DIM_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic set_dims(int r, int c);
    apb_access(1'b1, mfrs_pkg::REG_ROW_COUNT, mfrs_pkg::DIM_W'(r));
    apb_access(1'b1, mfrs_pkg::REG_COL_COUNT, mfrs_pkg::DIM_W'(c));
    apb_access(1'b0, mfrs_pkg::REG_ROW_COUNT, '0);
    apb_access(1'b0, mfrs_pkg::REG_COL_COUNT, '0);
    act_rows = (r == 0) ? 1 : (r > 8) ? 8 : r;
    act_cols = (c == 0) ? 1 : (c > 8) ? 8 : c;
  endtask

  task automatic load_value(logic [mfrs_pkg::DATA_W-1:0] v);
    mfrs_pkg::item_t it;
    it = make_item(mfrs_pkg::FUNC_LOAD);
    it.element = v;
    send(it);
    if (fill_idx < act_rows * act_cols) begin
      loaded[fill_idx] = 1'b1;
      fill_idx++;
      items_sent++;
    end
  endtask

  task automatic action_one(logic kind);
    mfrs_pkg::item_t it;
    it = make_item(mfrs_pkg::FUNC_ACTION);
    it.action_kind = kind;
    send(it);
    items_sent++;
  endtask

  task automatic finish_one();
    send(make_item(mfrs_pkg::FUNC_FINISH));
    fill_idx = 0;
    items_sent++;
    if ($urandom_range(7) == 0) wait_drained();
  endtask

  // Mostly full load + actions + finish; some partial loads and noise
  task automatic run_sequence();
    int area, shape, n_load, n_act;
    area  = act_rows * act_cols;
    shape = $urandom_range(99);
    if (shape < 75) begin
      n_load = area + (($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
      n_act  = $urandom_range(0, 6);
    end else if (shape < 90) begin
      n_load = $urandom_range(0, area - 1);
      n_act  = $urandom_range(0, 3);
    end else begin
      n_load = 0;
      n_act  = $urandom_range(0, 2);
    end
    while (n_load + n_act > 0) begin
      if ($urandom_range(1, n_load + n_act) <= n_load) begin
        load_value(16'($urandom));
        n_load--;
      end else begin
        action_one(1'($urandom));
        n_act--;
      end
      if ($urandom_range(19) == 0) send(make_item(FUNC_UNUSED));
    end
    if (store_ready()) finish_one();
  endtask

  initial begin : stimulus
    int ph, phase_end;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme values, identity, each action, overfill, unused code
    set_dims(2, 3);
    load_value(16'h8000);
    load_value(16'h7FFF);
    load_value(16'h0000);
    load_value(16'hFFFF);
    load_value(16'h5555);
    load_value(16'hAAAA);
    finish_one();
    action_one(mfrs_pkg::ACT_ROTATE);
    finish_one();
    action_one(mfrs_pkg::ACT_FLIP);
    finish_one();
    action_one(mfrs_pkg::ACT_FLIP);
    action_one(mfrs_pkg::ACT_ROTATE);
    action_one(mfrs_pkg::ACT_ROTATE);
    finish_one();
    repeat (7) load_value(16'($urandom));
    send(make_item(FUNC_UNUSED));
    action_one(mfrs_pkg::ACT_ROTATE);
    finish_one();

    // new shape over the same loaded data
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    set_dims(3, 2);
    finish_one();

    // random phases: each with its own shape and idle pattern
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clk);
      set_dims(cfg_rows[ph], cfg_cols[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      // long receiver hold-off while items keep coming
      if (ph == 4) hold_asked++;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_sequence();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d items over %0d register settings with all idle patterns",
             items_sent, PHASES + 2);
    $display("%0d matrices emitted, %0d result beats checked, %0d mismatches",
             matrices_done, beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("matrix_flip_rotate_sequence: match");
    end else begin
      $display("matrix_flip_rotate_sequence: mismatch");
    end
    $finish;
  end

endmodule
